[sv/mtp_pkg.sv]
package mtp_pkg;

    localparam int TICK_W     = 48;
    localparam int NOTE_SLOTS = 4096;
    localparam int SLOT_W     = $clog2(NOTE_SLOTS);
    localparam int DIDX_W     = SLOT_W + 1;
    localparam int PROD_W     = TICK_W + 16;
    localparam int OUT_T_W    = 48;
    localparam int MEM_W      = 1 + 8 + TICK_W;

    localparam logic [7:0] B_META  = 8'hFF;
    localparam logic [7:0] B_TEMPO = 8'h51;
    localparam logic [7:0] B_TSIG  = 8'h58;
    localparam logic [7:0] B_SYX0  = 8'hF0;
    localparam logic [7:0] B_SYX1  = 8'hF7;
    localparam logic [3:0] N_PROG  = 4'hC;
    localparam logic [3:0] N_PRESS = 4'hD;
    localparam logic [3:0] N_ON    = 4'h9;
    localparam logic [3:0] N_OFF   = 4'h8;

    typedef enum logic [2:0] {
        K_NOTE  = 3'd0,
        K_TEMPO = 3'd1,
        K_TSIG  = 3'd2,
        K_DRAIN = 3'd3,
        K_ABORT = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        A_BYTE  = 2'd0,
        A_DRAIN = 2'd1,
        A_NEW   = 2'd2,
        A_NONE  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        PH_DELTA, PH_STATUS, PH_DATA, PH_META_TYPE, PH_META_LEN,
        PH_META_BODY, PH_SYSEX_LEN, PH_SYSEX_BODY, PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        D_NONE, D_ABORT, D_TSIG, D_TEMPO, D_NOTE_ON, D_NOTE_OFF
    } t_dec;

    typedef struct packed {
        logic  take;
        logic  commit;
        logic  track_reset;
        logic  clear;
        logic  scan_init;
        logic  scan_next;
        logic  drain_set;
        logic  drain_end;
        logic  mem_rd;
        logic  mem_off;
        logic  rs_start;
        logic  rs_sel_cur;
        logic  lat_s;
        logic  lat_e;
        logic  load_out;
        t_kind out_kind;
    } t_cmd;

    typedef struct packed {
        t_action act;
        t_dec    dec;
        logic    clr_last;
        logic    drain_empty;
        logic    rd_on;
        logic    scan_last;
        logic    rs_done;
        logic    out_free;
    } t_sts;

endpackage

[sv/midi_track_event_parser.sv]
// channel   direction  handshake                 payload
// s_axis    in         i_s_tvalid / o_s_tready   tuser action, tdata byte and bytes left
// m_axis    out        o_m_tvalid / i_m_tready   tuser kind, tdata result fields
// cfg       in         i_cfg_valid / o_cfg_ready index 0 file division, 1 target resolution
//
// a track byte is taken and dispatched; a note-off also reads the note table and goes back to idle if no note sounds
// a note end runs two rescales through one shared divider, the note start tick and then the current tick
// tempo and time signature take one rescale
// a drain reads the note table slot by slot from the drain index on
// after reset and after a new-track request a clear sweep writes all 4096 slots, input held off
// a result waiting at the output holds back only the next request that has a result
module midi_track_event_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [1:0]    i_s_tuser,     // [1:0] action
    input  logic [39:0]   i_s_tdata,     // [7:0] data_byte, [39:8] bytes_left
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [2:0]    o_m_tuser,     // [2:0] kind
    output logic [159:0]  o_m_tdata,     // [47:0] start_tick, [95:48] length_ticks,
                                         // [99:96] channel, [107:100] key,
                                         // [115:108] velocity, [139:116] tempo_us,
                                         // [147:140] sig_numerator, [155:148] sig_exponent
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);
    import mtp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    mtp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mtp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_action    (i_s_tuser),
        .i_byte      (i_s_tdata[7:0]),
        .i_left      (i_s_tdata[39:8]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_kind      (o_m_tuser),
        .o_data      (o_m_tdata)
    );

`ifndef NO_ASSERTIONS
    // a note result always has a nonzero length
    a_note_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == K_NOTE |-> o_m_tdata[95:48] != '0)
        else $error("note result with zero length");

    // only note results carry a length
    a_len_only_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != K_NOTE |-> o_m_tdata[95:48] == '0)
        else $error("length on a non-note result");

    // a new track starts the clear sweep, no request taken right after
    a_clear_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.track_reset |=> !o_s_tready)
        else $error("request taken during table clear");

    // a result is only loaded when the output register is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !o_m_tvalid || i_m_tready)
        else $error("result overwritten before taken");
`endif

endmodule

[sv/mtp_rescale.sv]
module mtp_rescale (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mtp_pkg::TICK_W-1:0]   i_tick,
    input  logic [14:0]                  i_div,
    input  logic [15:0]                  i_tres,
    output logic                         o_done,
    output logic [mtp_pkg::PROD_W-1:0]   o_value
);
    import mtp_pkg::*;

    localparam int H     = TICK_W / 2;
    localparam int CNT_W = $clog2(TICK_W);

    typedef enum logic [2:0] {
        RS_IDLE, RS_DIV1, RS_MLO, RS_MHI, RS_MFR, RS_SUM, RS_DIV2
    } t_rs;

    t_rs                 r_state;
    logic [TICK_W-1:0]   r_num;
    logic [16:0]         r_rem;
    logic [15:0]         r_dv;
    logic [14:0]         r_d;
    logic [15:0]         r_tres;
    logic [CNT_W-1:0]    r_cnt;
    logic [TICK_W-1:0]   r_q;
    logic [14:0]         r_m;
    logic [PROD_W-1:0]   r_plo;
    logic [PROD_W-1:0]   r_phi;
    logic [30:0]         r_mt;
    logic [PROD_W-1:0]   r_qt;
    logic [PROD_W-1:0]   r_value;
    logic                r_done;

    logic [16:0]         rem_sh;
    logic                ge;
    logic [16:0]         rem_nx;
    logic [TICK_W-1:0]   num_nx;
    logic [H+15:0]       mlo;
    logic [TICK_W-H+15:0] mhi;
    logic [30:0]         mfr;
    logic [31:0]         num2;
    logic                last_step;

    // one quotient bit per cycle
    assign rem_sh    = {r_rem[15:0], r_num[TICK_W-1]};
    assign ge        = rem_sh >= {1'b0, r_dv};
    assign rem_nx    = ge ? rem_sh - {1'b0, r_dv} : rem_sh;
    assign num_nx    = {r_num[TICK_W-2:0], ge};
    assign last_step = r_cnt == CNT_W'(TICK_W - 1);

    // partial products, one per cycle
    assign mlo  = r_q[H-1:0] * r_tres;
    assign mhi  = r_q[TICK_W-1:H] * r_tres;
    assign mfr  = r_m * r_tres;
    assign num2 = {r_mt, 1'b0} + 32'(r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                RS_IDLE: begin
                    if (i_start) begin
                        r_num   <= i_tick;
                        r_rem   <= '0;
                        r_d     <= (i_div == '0) ? 15'd1 : i_div;
                        r_dv    <= (i_div == '0) ? 16'd1 : {1'b0, i_div};
                        r_tres  <= i_tres;
                        r_cnt   <= '0;
                        r_state <= RS_DIV1;
                    end
                end
                RS_DIV1: begin
                    r_num <= num_nx;
                    r_rem <= rem_nx;
                    r_cnt <= r_cnt + 1'b1;
                    if (last_step) begin
                        r_q     <= num_nx;
                        r_m     <= rem_nx[14:0];
                        r_state <= RS_MLO;
                    end
                end
                RS_MLO: begin
                    r_plo   <= PROD_W'(mlo);
                    r_state <= RS_MHI;
                end
                RS_MHI: begin
                    r_phi   <= PROD_W'(mhi);
                    r_state <= RS_MFR;
                end
                RS_MFR: begin
                    r_mt    <= mfr;
                    r_state <= RS_SUM;
                end
                RS_SUM: begin
                    r_qt    <= r_plo + (r_phi << H);
                    r_num   <= TICK_W'(num2);
                    r_rem   <= '0;
                    r_dv    <= {r_d, 1'b0};
                    r_cnt   <= '0;
                    r_state <= RS_DIV2;
                end
                RS_DIV2: begin
                    r_num <= num_nx;
                    r_rem <= rem_nx;
                    r_cnt <= r_cnt + 1'b1;
                    if (last_step) begin
                        r_value <= r_qt + PROD_W'(num_nx);
                        r_done  <= 1'b1;
                        r_state <= RS_IDLE;
                    end
                end
                default: r_state <= RS_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

[sv/mtp_datapath.sv]
module mtp_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mtp_pkg::t_cmd    i_cmd,
    output mtp_pkg::t_sts    o_sts,
    input  logic [1:0]       i_action,
    input  logic [7:0]       i_byte,
    input  logic [31:0]      i_left,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [2:0]       o_kind,
    output logic [159:0]     o_data
);
    import mtp_pkg::*;

    // configuration
    logic [14:0]          r_div;
    logic [15:0]          r_tres;
    // request
    t_action              r_act;
    logic [7:0]           r_byte;
    logic [31:0]          r_left;
    // parse state
    t_phase               r_phase;
    logic [7:0]           r_run;
    logic [TICK_W-1:0]    r_cur;
    logic [31:0]          r_delta;
    logic [2:0]           r_vlq;
    logic [7:0]           r_ev;
    logic [7:0]           r_meta;
    logic [31:0]          r_skip;
    logic [23:0]          r_payload;
    logic [7:0]           r_first;
    logic [DIDX_W-1:0]    r_drain;
    // event results
    logic [11:0]          r_slot;
    logic [7:0]           r_sig_a;
    logic [7:0]           r_sig_b;
    logic [23:0]          r_tempo;
    logic [PROD_W-1:0]    r_s;
    logic [PROD_W-1:0]    r_e;
    logic [SLOT_W-1:0]    r_clr;
    // note table
    logic [MEM_W-1:0]     r_mem [NOTE_SLOTS];
    logic [MEM_W-1:0]     r_rd;
    // result register
    logic                 r_ovalid;
    t_kind                r_okind;
    logic [159:0]         r_odata;

    t_phase               n_phase;
    logic [7:0]           n_run;
    logic [TICK_W-1:0]    n_cur;
    logic [31:0]          n_delta;
    logic [2:0]           n_vlq;
    logic [7:0]           n_ev;
    logic [7:0]           n_meta;
    logic [31:0]          n_skip;
    logic [23:0]          n_payload;
    logic [7:0]           n_first;
    logic [11:0]          n_slot;
    logic [7:0]           n_sig_a;
    logic [7:0]           n_sig_b;
    logic [23:0]          n_tempo;
    t_dec                 dec;

    logic                 last;
    logic [31:0]          acc;
    logic [2:0]           cnt;
    logic                 vlq_done;
    logic                 vlq_long;
    logic                 rs_done;
    logic [PROD_W-1:0]    rs_value;
    logic [PROD_W-1:0]    len_raw;
    logic [OUT_T_W-1:0]   len;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_wa;
    logic [MEM_W-1:0]     mem_wd;

    assign last     = r_left == '0;
    assign acc      = {r_delta[24:0], r_byte[6:0]};
    assign cnt      = r_vlq + 3'd1;
    assign vlq_done = !r_byte[7];
    assign vlq_long = r_byte[7] && (cnt >= 3'd5);

    // byte parser
    always_comb begin
        logic       ab;
        logic       more;
        logic       end_ev;
        logic       dbyte;
        logic [7:0] es;
        logic [2:0] vc;
        logic [3:0] nk;
        logic [31:0] sk;
        logic [2:0] bc;
        n_phase   = r_phase;
        n_run     = r_run;
        n_cur     = r_cur;
        n_delta   = r_delta;
        n_vlq     = r_vlq;
        n_ev      = r_ev;
        n_meta    = r_meta;
        n_skip    = r_skip;
        n_payload = r_payload;
        n_first   = r_first;
        n_slot    = r_slot;
        n_sig_a   = r_sig_a;
        n_sig_b   = r_sig_b;
        n_tempo   = r_tempo;
        dec       = D_NONE;
        ab        = 1'b0;
        more      = 1'b0;
        end_ev    = 1'b0;
        dbyte     = 1'b0;
        es        = r_ev;
        vc        = r_vlq;
        sk        = r_skip - 32'd1;
        bc        = (r_vlq < 3'd7) ? r_vlq + 3'd1 : 3'd7;
        unique case (r_phase)
            PH_DELTA: begin
                n_delta = acc;
                n_vlq   = cnt;
                if (vlq_long) begin
                    ab = 1'b1;
                end else if (!vlq_done) begin
                    more = 1'b1;
                end else begin
                    n_cur   = r_cur + TICK_W'(acc);
                    n_phase = PH_STATUS;
                    more    = 1'b1;
                end
            end
            PH_STATUS: begin
                n_delta = '0;
                n_vlq   = '0;
                if (r_byte == B_META) begin
                    n_phase = PH_META_TYPE;
                    more    = 1'b1;
                end else if (r_byte == B_SYX0 || r_byte == B_SYX1) begin
                    n_phase = PH_SYSEX_LEN;
                    more    = 1'b1;
                end else if (r_byte[7]) begin
                    n_run   = r_byte;
                    n_ev    = r_byte;
                    n_phase = PH_DATA;
                    more    = 1'b1;
                end else if (r_run == '0) begin
                    ab = 1'b1;
                end else begin
                    n_ev    = r_run;
                    n_phase = PH_DATA;
                    es      = r_run;
                    vc      = '0;
                    dbyte   = 1'b1;
                end
            end
            PH_DATA: dbyte = 1'b1;
            PH_META_TYPE: begin
                n_meta  = r_byte;
                n_delta = '0;
                n_vlq   = '0;
                n_phase = PH_META_LEN;
                more    = 1'b1;
            end
            PH_META_LEN, PH_SYSEX_LEN: begin
                n_delta = acc;
                n_vlq   = cnt;
                if (vlq_long) begin
                    ab = 1'b1;
                end else if (!vlq_done) begin
                    more = 1'b1;
                end else if (acc > r_left) begin
                    ab = 1'b1;
                end else begin
                    n_skip    = acc;
                    n_payload = '0;
                    if (acc == '0) begin
                        end_ev = 1'b1;
                    end else begin
                        n_vlq   = '0;
                        n_phase = (r_phase == PH_META_LEN) ? PH_META_BODY : PH_SYSEX_BODY;
                    end
                end
            end
            PH_META_BODY: begin
                n_skip    = sk;
                n_vlq     = bc;
                n_payload = {r_payload[15:0], r_byte};
                if (bc == 3'd1) begin
                    n_first = r_byte;
                end
                if (sk != '0 && last) begin
                    ab = 1'b1;
                end else begin
                    if (sk == '0) begin
                        end_ev = 1'b1;
                    end
                    if (r_meta == B_TSIG && bc == 3'd2) begin
                        dec     = D_TSIG;
                        n_sig_a = r_first;
                        n_sig_b = r_byte;
                    end else if (r_meta == B_TEMPO && bc == 3'd3 && sk == '0) begin
                        dec     = D_TEMPO;
                        n_tempo = (n_payload == '0) ? 24'd1 : n_payload;
                    end
                end
            end
            PH_SYSEX_BODY: begin
                n_skip = sk;
                if (sk == '0) begin
                    end_ev = 1'b1;
                end else begin
                    more = 1'b1;
                end
            end
            default: ;
        endcase

        // channel data byte
        nk = es[7:4];
        if (dbyte) begin
            if (vc == '0) begin
                n_first = r_byte;
                n_vlq   = 3'd1;
                if (nk == N_PROG || nk == N_PRESS) begin
                    end_ev = 1'b1;
                end else begin
                    more = 1'b1;
                end
            end else begin
                end_ev = 1'b1;
                n_slot = {es[3:0], r_first};
                if (DIDX_W'(n_slot) < DIDX_W'(NOTE_SLOTS)) begin
                    if (nk == N_ON && r_byte != '0) begin
                        dec = D_NOTE_ON;
                    end else if (nk == N_OFF || nk == N_ON) begin
                        dec = D_NOTE_OFF;
                    end
                end
            end
        end

        if (end_ev) begin
            n_phase = last ? PH_DONE : PH_DELTA;
            n_delta = '0;
            n_vlq   = '0;
        end
        if (more && last) begin
            ab = 1'b1;
        end
        if (ab) begin
            n_phase = PH_DONE;
            dec     = D_ABORT;
        end
    end

    // configuration, request and parse registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div     <= 15'd480;
            r_tres    <= 16'd960;
            r_act     <= A_NONE;
            r_phase   <= PH_DELTA;
            r_run     <= '0;
            r_cur     <= '0;
            r_delta   <= '0;
            r_vlq     <= '0;
            r_ev      <= '0;
            r_meta    <= '0;
            r_skip    <= '0;
            r_payload <= '0;
            r_first   <= '0;
            r_drain   <= '0;
            r_clr     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == 2'd0) begin
                r_div <= i_cfg_data[14:0];
            end
            if (i_cfg_we && i_cfg_index == 2'd1) begin
                r_tres <= i_cfg_data;
            end
            if (i_cmd.take) begin
                r_act  <= t_action'(i_action);
                r_byte <= i_byte;
                r_left <= i_left;
            end
            if (i_cmd.track_reset) begin
                r_phase   <= PH_DELTA;
                r_run     <= '0;
                r_cur     <= '0;
                r_delta   <= '0;
                r_vlq     <= '0;
                r_ev      <= '0;
                r_meta    <= '0;
                r_skip    <= '0;
                r_payload <= '0;
                r_first   <= '0;
                r_drain   <= '0;
                r_clr     <= '0;
            end else if (i_cmd.commit) begin
                r_phase   <= n_phase;
                r_run     <= n_run;
                r_cur     <= n_cur;
                r_delta   <= n_delta;
                r_vlq     <= n_vlq;
                r_ev      <= n_ev;
                r_meta    <= n_meta;
                r_skip    <= n_skip;
                r_payload <= n_payload;
                r_first   <= n_first;
                if (dec == D_NOTE_ON && DIDX_W'(n_slot) < r_drain) begin
                    r_drain <= DIDX_W'(n_slot);
                end
            end else if (i_cmd.drain_set) begin
                r_drain <= DIDX_W'(r_slot) + 1'b1;
            end else if (i_cmd.drain_end) begin
                r_drain <= DIDX_W'(NOTE_SLOTS);
            end
            if (i_cmd.clear) begin
                r_clr <= r_clr + 1'b1;
            end
            // result register
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // event payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_slot  <= n_slot;
            r_sig_a <= n_sig_a;
            r_sig_b <= n_sig_b;
            r_tempo <= n_tempo;
        end else if (i_cmd.scan_init) begin
            r_slot <= 12'(r_drain[SLOT_W-1:0]);
        end else if (i_cmd.scan_next) begin
            r_slot <= r_slot + 1'b1;
        end
        if (i_cmd.lat_s) begin
            r_s <= rs_value;
        end
        if (i_cmd.lat_e) begin
            r_e <= rs_value;
        end
    end

    // note table port: clear sweep, note start, note end
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_slot[SLOT_W-1:0];
        mem_wd = '0;
        if (i_cmd.clear) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
        end else if (i_cmd.commit && dec == D_NOTE_ON) begin
            mem_we = 1'b1;
            mem_wa = n_slot[SLOT_W-1:0];
            mem_wd = {1'b1, r_byte, r_cur};
        end else if (i_cmd.mem_off) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.mem_rd) begin
            r_rd <= r_mem[r_slot[SLOT_W-1:0]];
        end
    end

    mtp_rescale u_rescale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.rs_start),
        .i_tick  (i_cmd.rs_sel_cur ? r_cur : r_rd[TICK_W-1:0]),
        .i_div   (r_div),
        .i_tres  (r_tres),
        .o_done  (rs_done),
        .o_value (rs_value)
    );

    // note length, at least one and saturated
    assign len_raw = (r_e > r_s) ? r_e - r_s : PROD_W'(1);
    assign len     = (len_raw > PROD_W'({OUT_T_W{1'b1}})) ? {OUT_T_W{1'b1}}
                                                           : len_raw[OUT_T_W-1:0];

    // result fields by kind
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_okind <= i_cmd.out_kind;
            r_odata <= '0;
            unique case (i_cmd.out_kind)
                K_NOTE: begin
                    r_odata[47:0]    <= r_s[OUT_T_W-1:0];
                    r_odata[95:48]   <= len;
                    r_odata[99:96]   <= r_slot[11:8];
                    r_odata[107:100] <= r_slot[7:0];
                    r_odata[115:108] <= r_rd[MEM_W-2:TICK_W];
                end
                K_TEMPO: begin
                    r_odata[47:0]    <= r_s[OUT_T_W-1:0];
                    r_odata[139:116] <= r_tempo;
                end
                K_TSIG: begin
                    r_odata[47:0]    <= r_s[OUT_T_W-1:0];
                    r_odata[147:140] <= r_sig_a;
                    r_odata[155:148] <= r_sig_b;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_kind      = r_okind;
    assign o_data      = r_odata;

    assign o_sts.act         = r_act;
    assign o_sts.dec         = dec;
    assign o_sts.clr_last    = r_clr == SLOT_W'(NOTE_SLOTS - 1);
    assign o_sts.drain_empty = r_drain == DIDX_W'(NOTE_SLOTS);
    assign o_sts.rd_on       = r_rd[MEM_W-1];
    assign o_sts.scan_last   = r_slot == 12'(NOTE_SLOTS - 1);
    assign o_sts.rs_done     = rs_done;
    assign o_sts.out_free    = !r_ovalid || i_out_ready;

endmodule

[sv/mtp_ctrl.sv]
module mtp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mtp_pkg::t_sts  i_sts,
    output mtp_pkg::t_cmd  o_cmd
);
    import mtp_pkg::*;

    typedef enum logic [3:0] {
        C_CLR, C_IDLE, C_DISP, C_NRD, C_NCK, C_SRD, C_SCK,
        C_RS_S, C_RS_E, C_RS_M, C_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    t_kind  r_kind;
    t_kind  n_kind;

    // next state and commands
    always_comb begin
        n_state        = r_state;
        n_kind         = r_kind;
        o_cmd          = '0;
        o_cmd.out_kind = r_kind;
        o_in_ready     = 1'b0;
        unique case (r_state)
            C_CLR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = C_IDLE;
                end
            end
            C_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = C_DISP;
                end
            end
            C_DISP: begin
                unique case (i_sts.act)
                    A_NEW: begin
                        o_cmd.track_reset = 1'b1;
                        n_state           = C_CLR;
                    end
                    A_NONE: n_state = C_IDLE;
                    A_DRAIN: begin
                        if (i_sts.drain_empty) begin
                            n_kind  = K_DRAIN;
                            n_state = C_OUT;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = C_SRD;
                        end
                    end
                    A_BYTE: begin
                        o_cmd.commit = 1'b1;
                        unique case (i_sts.dec)
                            D_ABORT: begin
                                n_kind  = K_ABORT;
                                n_state = C_OUT;
                            end
                            D_TSIG, D_TEMPO: begin
                                o_cmd.rs_start   = 1'b1;
                                o_cmd.rs_sel_cur = 1'b1;
                                n_kind  = (i_sts.dec == D_TSIG) ? K_TSIG : K_TEMPO;
                                n_state = C_RS_M;
                            end
                            D_NOTE_OFF: n_state = C_NRD;
                            default:    n_state = C_IDLE;
                        endcase
                    end
                    default: n_state = C_IDLE;
                endcase
            end
            C_NRD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = C_NCK;
            end
            C_NCK: begin
                if (i_sts.rd_on) begin
                    o_cmd.rs_start = 1'b1;
                    n_kind         = K_NOTE;
                    n_state        = C_RS_S;
                end else begin
                    n_state = C_IDLE;
                end
            end
            C_SRD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = C_SCK;
            end
            C_SCK: begin
                if (i_sts.rd_on) begin
                    o_cmd.drain_set = 1'b1;
                    o_cmd.rs_start  = 1'b1;
                    n_kind          = K_NOTE;
                    n_state         = C_RS_S;
                end else if (i_sts.scan_last) begin
                    o_cmd.drain_end = 1'b1;
                    n_kind          = K_DRAIN;
                    n_state         = C_OUT;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = C_SRD;
                end
            end
            C_RS_S: begin
                if (i_sts.rs_done) begin
                    o_cmd.lat_s      = 1'b1;
                    o_cmd.rs_start   = 1'b1;
                    o_cmd.rs_sel_cur = 1'b1;
                    n_state          = C_RS_E;
                end
            end
            C_RS_E: begin
                if (i_sts.rs_done) begin
                    o_cmd.lat_e   = 1'b1;
                    o_cmd.mem_off = 1'b1;
                    n_state       = C_OUT;
                end
            end
            C_RS_M: begin
                if (i_sts.rs_done) begin
                    o_cmd.lat_s = 1'b1;
                    n_state     = C_OUT;
                end
            end
            C_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = C_IDLE;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    // state and result kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_CLR;
            r_kind  <= K_NOTE;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

[sim/tb.sv]
module tb;
    import mtp_pkg::*;

    localparam logic [1:0] REG_DIV = 2'd0;
    localparam logic [1:0] REG_RES = 2'd1;
    localparam int IDLE_WAIT = 300;
    localparam int HANG_LIMIT = 30000;
    localparam longint unsigned MAX48 = 64'hFFFF_FFFF_FFFF;

    typedef struct packed {
        t_kind       kind;
        logic [47:0] start;
        logic [47:0] len;
        logic [3:0]  ch;
        logic [7:0]  key;
        logic [7:0]  vel;
        logic [23:0] tempo;
        logic [7:0]  sig_num;
        logic [7:0]  sig_exp;
    } t_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [1:0]   i_s_tuser = '0;
    logic [39:0]  i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [2:0]   o_m_tuser;
    logic [159:0] o_m_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [15:0]  i_cfg_data = '0;

    midi_track_event_parser dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // parser state as the block should hold it
    logic [14:0] file_div = 15'd480;
    logic [15:0] target_res = 16'd960;
    t_phase      phase;
    logic [7:0]  run_status, ev_status, meta_kind, first_byte;
    logic [47:0] tick;
    logic [31:0] delta_acc;
    int unsigned vlq_cnt, skip_left;
    logic [23:0] payload;
    bit          note_on [NOTE_SLOTS];
    logic [47:0] note_tick [NOTE_SLOTS];
    logic [7:0]  note_vel [NOTE_SLOTS];
    int          drain_idx;

    t_res        expected_events [$];
    int          fails = 0;
    int          n_sent = 0;
    bit          steady = 0;
    int          hang_cnt = 0;
    int          m_stall = 0;

    function automatic void track_clear();
        phase = PH_DELTA;
        run_status = '0;
        ev_status = '0;
        meta_kind = '0;
        first_byte = '0;
        tick = '0;
        delta_acc = '0;
        vlq_cnt = 0;
        skip_left = 0;
        payload = '0;
        drain_idx = 0;
        foreach (note_on[i]) begin
            note_on[i] = 0;
            note_tick[i] = '0;
            note_vel[i] = '0;
        end
    endfunction

    // t * target / division, rounded half up, 64-bit wrapping
    function automatic longint unsigned rescale(logic [47:0] t);
        longint unsigned d, tr, q, m;
        d = (file_div == 0) ? 64'd1 : 64'(file_div);
        tr = 64'(target_res);
        q = 64'(t) / d;
        m = 64'(t) % d;
        return q * tr + (2 * m * tr + d) / (2 * d);
    endfunction

    function automatic t_res end_note(int slot);
        t_res r;
        longint unsigned s, e, len;
        r = '0;
        s = rescale(note_tick[slot]);
        e = rescale(tick);
        len = (e > s) ? e - s : 64'd1;
        if (len > MAX48)
            len = MAX48;
        r.kind = K_NOTE;
        r.start = s[47:0];
        r.len = len[47:0];
        r.ch = slot[11:8];
        r.key = slot[7:0];
        r.vel = note_vel[slot];
        note_on[slot] = 0;
        return r;
    endfunction

    function automatic bit quit(inout t_res r);
        phase = PH_DONE;
        r = '0;
        r.kind = K_ABORT;
        return 1;
    endfunction

    function automatic bit more(bit last, inout t_res r);
        if (last)
            return quit(r);
        return 0;
    endfunction

    function automatic void event_end(bit last);
        phase = last ? PH_DONE : PH_DELTA;
        delta_acc = '0;
        vlq_cnt = 0;
    endfunction

    // 0 more bytes, 1 complete, 2 too long
    function automatic int vlq_take(logic [7:0] b);
        delta_acc = (delta_acc << 7) | 32'(b[6:0]);
        vlq_cnt++;
        if (!b[7])
            return 1;
        return (vlq_cnt >= 5) ? 2 : 0;
    endfunction

    function automatic bit channel_data(logic [7:0] b, bit last, inout t_res r);
        logic [3:0] hi;
        int slot;
        hi = ev_status[7:4];
        if (vlq_cnt == 0) begin
            first_byte = b;
            vlq_cnt = 1;
            if (hi == N_PROG || hi == N_PRESS) begin
                event_end(last);
                return 0;
            end
            return more(last, r);
        end
        event_end(last);
        slot = {ev_status[3:0], first_byte};
        if (hi == N_ON && b != 0) begin
            note_on[slot] = 1;
            note_tick[slot] = tick;
            note_vel[slot] = b;
            if (slot < drain_idx)
                drain_idx = slot;
            return 0;
        end
        if ((hi == N_OFF || hi == N_ON) && note_on[slot]) begin
            r = end_note(slot);
            return 1;
        end
        return 0;
    endfunction

    function automatic bit parse_track_step(t_action act, logic [7:0] b, logic [31:0] left,
                                            output t_res r);
        bit last;
        int code;
        int unsigned cnt;
        r = '0;
        last = (left == 0);
        case (act)
            A_NEW: begin
                track_clear();
                return 0;
            end
            A_NONE: return 0;
            A_DRAIN: begin
                for (int s = drain_idx; s < NOTE_SLOTS; s++) begin
                    if (note_on[s]) begin
                        drain_idx = s + 1;
                        r = end_note(s);
                        return 1;
                    end
                end
                drain_idx = NOTE_SLOTS;
                r.kind = K_DRAIN;
                return 1;
            end
            default: ;
        endcase
        case (phase)
            PH_DELTA: begin
                code = vlq_take(b);
                if (code == 2)
                    return quit(r);
                if (code == 0)
                    return more(last, r);
                tick = tick + 48'(delta_acc);
                phase = PH_STATUS;
                return more(last, r);
            end
            PH_STATUS: begin
                delta_acc = '0;
                vlq_cnt = 0;
                if (b == B_META) begin
                    phase = PH_META_TYPE;
                    return more(last, r);
                end
                if (b == B_SYX0 || b == B_SYX1) begin
                    phase = PH_SYSEX_LEN;
                    return more(last, r);
                end
                if (b[7]) begin
                    run_status = b;
                    ev_status = b;
                    phase = PH_DATA;
                    return more(last, r);
                end
                if (run_status == 0)
                    return quit(r);
                ev_status = run_status;
                phase = PH_DATA;
                return channel_data(b, last, r);
            end
            PH_DATA: return channel_data(b, last, r);
            PH_META_TYPE: begin
                meta_kind = b;
                delta_acc = '0;
                vlq_cnt = 0;
                phase = PH_META_LEN;
                return more(last, r);
            end
            PH_META_LEN, PH_SYSEX_LEN: begin
                code = vlq_take(b);
                if (code == 2)
                    return quit(r);
                if (code == 0)
                    return more(last, r);
                if (delta_acc > left)
                    return quit(r);
                skip_left = delta_acc;
                payload = '0;
                if (skip_left == 0) begin
                    event_end(last);
                    return 0;
                end
                vlq_cnt = 0;
                phase = (phase == PH_META_LEN) ? PH_META_BODY : PH_SYSEX_BODY;
                return 0;
            end
            PH_META_BODY: begin
                skip_left--;
                cnt = (vlq_cnt < 7) ? vlq_cnt + 1 : 7;
                vlq_cnt = cnt;
                payload = {payload[15:0], b};
                if (cnt == 1)
                    first_byte = b;
                if (skip_left != 0 && last)
                    return quit(r);
                if (skip_left == 0)
                    event_end(last);
                if (meta_kind == B_TSIG && cnt == 2) begin
                    r.kind = K_TSIG;
                    r.start = rescale(tick);
                    r.sig_num = first_byte;
                    r.sig_exp = b;
                    return 1;
                end
                if (meta_kind == B_TEMPO && cnt == 3 && skip_left == 0) begin
                    r.kind = K_TEMPO;
                    r.start = rescale(tick);
                    r.tempo = (payload == 0) ? 24'd1 : payload;
                    return 1;
                end
                return 0;
            end
            PH_SYSEX_BODY: begin
                skip_left--;
                if (skip_left == 0) begin
                    event_end(last);
                    return 0;
                end
                return more(last, r);
            end
            default: return 0;
        endcase
    endfunction

    // result checking
    function automatic void cmp_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_events.size() == 0) begin
                $error("unexpected result, kind %0d", o_m_tuser);
                fails++;
            end else begin
                w = expected_events.pop_front();
                cmp_field("kind", w.kind, o_m_tuser);
                cmp_field("start_tick", w.start, o_m_tdata[47:0]);
                cmp_field("length_ticks", w.len, o_m_tdata[95:48]);
                cmp_field("channel", w.ch, o_m_tdata[99:96]);
                cmp_field("key", w.key, o_m_tdata[107:100]);
                cmp_field("velocity", w.vel, o_m_tdata[115:108]);
                cmp_field("tempo_us", w.tempo, o_m_tdata[139:116]);
                cmp_field("sig_numerator", w.sig_num, o_m_tdata[147:140]);
                cmp_field("sig_exponent", w.sig_exp, o_m_tdata[155:148]);
                cmp_field("tdata padding", 0, o_m_tdata[159:156]);
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            hang_cnt <= 0;
        else if (hang_cnt >= HANG_LIMIT) begin
            $display("FAIL midi_track_event_parser");
            $finish;
        end else
            hang_cnt <= hang_cnt + 1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // output back-pressure
    always @(negedge i_clk) begin
        if (m_stall > 0) begin
            i_m_tready <= 1'b0;
            m_stall <= m_stall - 1;
        end else begin
            i_m_tready <= 1'b1;
            if (!steady && $urandom_range(0, 5) == 0)
                m_stall <= pick_gap();
        end
    end

    task automatic send_item(t_action act, logic [7:0] b, logic [31:0] left);
        int g;
        t_res r;
        if (n_sent % 50 == 0)
            steady = ($urandom_range(0, 3) == 0);
        g = pick_gap();
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= act;
        i_s_tdata <= {left, b};
        do @(posedge i_clk); while (!o_s_tready);
        if (parse_track_step(act, b, left, r))
            expected_events.push_back(r);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_DIV)
            file_div = val[14:0];
        else
            target_res = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // track byte generation
    logic [7:0] track_bytes [$];
    logic [7:0] gen_rs;

    task automatic add_vlq(int unsigned v, int pad);
        logic [7:0] grp [$];
        do begin
            grp.push_front({1'b0, v[6:0]});
            v = v >> 7;
        end while (v != 0);
        while (pad > 0 && grp.size() < 5) begin
            grp.push_front(8'h00);
            pad--;
        end
        foreach (grp[i])
            track_bytes.push_back((i < grp.size() - 1) ? (grp[i] | 8'h80) : grp[i]);
    endtask

    task automatic add_delta();
        int r;
        int unsigned v;
        r = $urandom_range(0, 99);
        if (r < 40)
            v = 0;
        else if (r < 80)
            v = $urandom_range(1, 127);
        else if (r < 95)
            v = $urandom_range(128, 20000);
        else
            v = $urandom;
        add_vlq(v, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0);
    endtask

    function automatic logic [7:0] pick_key();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'h7F;
            2: return 8'h80;
            3: return 8'hFF;
            default: return 8'($urandom_range(8'h3C, 8'h3F));
        endcase
    endfunction

    // channel-style event, status left out when running status allows
    task automatic add_chan(logic [7:0] st, logic [7:0] d0, logic [7:0] d1, bit two);
        if (!(st == gen_rs && !d0[7] && $urandom_range(0, 1)))
            track_bytes.push_back(st);
        gen_rs = st;
        track_bytes.push_back(d0);
        if (two)
            track_bytes.push_back(d1);
    endtask

    task automatic add_meta(logic [7:0] typ, int len, bit zero);
        track_bytes.push_back(B_META);
        track_bytes.push_back(typ);
        add_vlq(len, 0);
        repeat (len) track_bytes.push_back(zero ? 8'h00 : 8'($urandom));
    endtask

    task automatic add_event();
        int r;
        logic [3:0] ch;
        logic [7:0] st;
        r = $urandom_range(0, 99);
        ch = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
        if (r < 32)
            add_chan({N_ON, ch}, pick_key(),
                     ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(1, 255)), 1);
        else if (r < 52)
            add_chan({N_OFF, ch}, pick_key(), 8'($urandom), 1);
        else if (r < 58)
            add_chan({($urandom_range(0, 1) ? N_PROG : N_PRESS), ch}, 8'($urandom), 8'h00, 0);
        else if (r < 63) begin
            do st = 8'($urandom_range(8'hF1, 8'hFE)); while (st == B_SYX1);
            add_chan(st, 8'($urandom), 8'($urandom), 1);
        end else if (r < 71)
            add_meta(B_TEMPO, 3, $urandom_range(0, 5) == 0);
        else if (r < 78)
            add_meta(B_TSIG, $urandom_range(2, 5), 0);
        else if (r < 87) begin
            case ($urandom_range(0, 3))
                0: st = B_TEMPO;
                1: st = B_TSIG;
                default: st = 8'($urandom);
            endcase
            add_meta(st, $urandom_range(0, 6), 0);
        end else begin
            track_bytes.push_back($urandom_range(0, 1) ? B_SYX0 : B_SYX1);
            r = $urandom_range(0, 6);
            add_vlq(r, 0);
            repeat (r) track_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic build_track(int n_events);
        track_bytes.delete();
        gen_rs = 8'h00;
        repeat (n_events) begin
            add_delta();
            add_event();
        end
    endtask

    // mode 0 whole, 1 cut short, 2 one byte corrupted
    task automatic play_track(int mode);
        int n;
        n = track_bytes.size();
        if (mode == 1)
            n = $urandom_range(1, n);
        if (mode == 2)
            track_bytes[$urandom_range(0, n - 1)] = 8'($urandom);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 29) == 0)
                send_item(A_DRAIN, 8'($urandom), $urandom);
            send_item(A_BYTE, track_bytes[i], 32'(n - 1 - i));
        end
        if ($urandom_range(0, 1))
            repeat ($urandom_range(1, 6)) send_item(A_DRAIN, 8'($urandom), $urandom);
        send_item(A_NEW, 8'($urandom), $urandom);
    endtask

    task automatic send_list(logic [7:0] bl [$]);
        foreach (bl[i])
            send_item(A_BYTE, bl[i], 32'(bl.size() - 1 - i));
    endtask

    // tempo zero, time signature, note on then running-status note off, empty drain
    task automatic test_directed();
        send_item(A_NEW, 8'h00, 32'h0);
        send_list('{8'h00, B_META, B_TEMPO, 8'h03, 8'h00, 8'h00, 8'h00,
                    8'h00, B_META, B_TSIG, 8'h04, 8'h04, 8'h02, 8'h18, 8'h08,
                    8'h00, 8'h90, 8'h3C, 8'h7F, 8'hFF, 8'h7F, 8'h3C, 8'h00});
        send_item(A_DRAIN, 8'hFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_malformed();
        // six-byte delta
        send_item(A_NEW, 8'h00, 32'h0);
        repeat (5) send_item(A_BYTE, 8'h80, $urandom);
        send_item(A_BYTE, 8'h00, 32'h100);
        send_item(A_BYTE, 8'h00, 32'h100);
        // data byte with no running status
        send_item(A_NEW, 8'h00, 32'h0);
        send_list('{8'h00, 8'h40, 8'h40});
        // meta length past the chunk end
        send_item(A_NEW, 8'h00, 32'h0);
        send_list('{8'h00, B_META, 8'h01, 8'h05});
        send_item(A_NONE, 8'hA5, $urandom);
        send_item(A_NEW, 8'h00, 32'h0);
        repeat (10) begin
            build_track($urandom_range(3, 10));
            play_track($urandom_range(1, 2));
        end
    endtask

    task automatic test_settings();
        logic [15:0] divs [6] = '{16'd480, 16'd1, 16'hFFFF, 16'h8000, 16'd7, 16'd0};
        logic [15:0] ress [6] = '{16'd960, 16'd1, 16'hFFFF, 16'hFFFF, 16'd3, 16'd0};
        int goal;
        divs[5] = 16'($urandom);
        ress[5] = 16'($urandom);
        for (int k = 0; k < 6; k++) begin
            cfg_write(REG_DIV, divs[k]);
            cfg_write(REG_RES, ress[k]);
            goal = n_sent + 200;
            while (n_sent < goal) begin
                build_track($urandom_range(2, 12));
                play_track(($urandom_range(0, 9) == 0) ? 1 : 0);
            end
        end
    endtask

    task automatic test_noise();
        int r;
        repeat (150) begin
            r = $urandom_range(0, 19);
            send_item((r == 0) ? A_DRAIN : (r == 1) ? A_NONE : (r == 2) ? A_NEW : A_BYTE,
                      8'($urandom), $urandom);
        end
        send_item(A_NEW, 8'h00, 32'h0);
    endtask

    initial begin
        track_clear();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_malformed();
        test_settings();
        test_noise();
        wait_idle();
        if (fails == 0)
            $display("PASS midi_track_event_parser");
        else
            $display("FAIL midi_track_event_parser");
        $finish;
    end

endmodule

[files.f]
sv/mtp_pkg.sv
sv/mtp_rescale.sv
sv/mtp_datapath.sv
sv/mtp_ctrl.sv
sv/midi_track_event_parser.sv
sim/tb.sv
